// ===== hw/rtl/smoothed_frequency_meter_defines.svh =====
// Assertion macros shared by the RTL files of the smoothed frequency meter.
`ifndef SMOOTHED_FREQUENCY_METER_DEFINES_SVH
`define SMOOTHED_FREQUENCY_METER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define SFM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfm: same-cycle property violated");
// Next-cycle implication, checked at every rising edge outside reset.
`define SFM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfm: next-cycle property violated");
`else
`define SFM_ASSERT_NOW(label, clk, rst, ante, cons)
`define SFM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/sfm_pkg.sv =====
// Shared constants and controller/datapath types of the smoothed frequency meter.
package sfm_pkg;

   localparam int STAMP_W    = 32;
   localparam int COUNT_W    = 16;
   localparam int SUM_W      = 32;
   localparam int FREQ_W     = 40;
   localparam int MOM_W      = 16;
   localparam int WIN_W      = 24;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 24;
   localparam int MULT_W     = 20;
   localparam int PROD_W     = SUM_W + MULT_W;
   localparam int DIV_CNT_W  = $clog2(FREQ_W);

   localparam logic [MULT_W-1:0] US_PER_SEC = 20'd1000000;
   localparam logic [MOM_W:0]    ONE_Q16    = 17'h10000;

   localparam logic [MOM_W-1:0] MOMENTUM_RESET = 16'd58982;
   localparam logic [WIN_W-1:0] WINDOW_RESET   = 24'd30000;

   localparam logic [CSR_IDX_W-1:0] CSR_MOMENTUM = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW   = 1'b1;

   localparam logic ACTION_COUNT   = 1'b0;
   localparam logic ACTION_RESTART = 1'b1;

   typedef struct packed {
      logic load_item;
      logic accumulate;
      logic mul;
      logic div_init;
      logic div_step;
      logic blend_mul;
      logic blend_sum;
      logic load_out;
   } sfm_cmd_type;

   typedef struct packed {
      logic win_closed;
      logic rate_sat;
      logic div_last;
      logic out_free;
   } sfm_stat_type;

endpackage

// ===== hw/rtl/sfm_ifs.sv =====
// Valid/ready channel interfaces: request items, result items and register writes.
interface sfm_req_if;
   logic                         valid;
   logic                         ready;
   logic                         action;
   logic [sfm_pkg::STAMP_W-1:0]  timestamp_us;
   logic [sfm_pkg::COUNT_W-1:0]  event_count;

   modport source (output valid, action, timestamp_us, event_count, input ready);
   modport sink   (input valid, action, timestamp_us, event_count, output ready);
endinterface

interface sfm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [sfm_pkg::FREQ_W-1:0]   frequency_q8;
   logic                         updated;

   modport source (output valid, frequency_q8, updated, input ready);
   modport sink   (input valid, frequency_q8, updated, output ready);
endinterface

interface sfm_csr_if;
   logic                            valid;
   logic                            ready;
   logic [sfm_pkg::CSR_IDX_W-1:0]   index;
   logic [sfm_pkg::CSR_DATA_W-1:0]  wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

// ===== hw/rtl/sfm_ctrl.sv =====
// Controller state machine that sequences one item through the datapath.
`include "smoothed_frequency_meter_defines.svh"

module sfm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output sfm_pkg::sfm_cmd_type  cmd,
   input  sfm_pkg::sfm_stat_type stat
);
   import sfm_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_ACC   = 9'b000000010,
      ST_CHK   = 9'b000000100,
      ST_MUL   = 9'b000001000,
      ST_DINIT = 9'b000010000,
      ST_DIV   = 9'b000100000,
      ST_BMUL  = 9'b001000000,
      ST_BSUM  = 9'b010000000,
      ST_OUT   = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_ACC;
            end
         end
         ST_ACC: begin
            cmd.accumulate = 1'b1;
            state_in       = ST_CHK;
         end
         ST_CHK: begin
            state_in = stat.win_closed ? ST_MUL : ST_OUT;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DINIT;
         end
         ST_DINIT: begin
            // A rate that cannot fit in the output saturates without iterating.
            cmd.div_init = 1'b1;
            state_in     = stat.rate_sat ? ST_BMUL : ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_BMUL;
            end
         end
         ST_BMUL: begin
            cmd.blend_mul = 1'b1;
            state_in      = ST_BSUM;
         end
         ST_BSUM: begin
            cmd.blend_sum = 1'b1;
            state_in      = ST_OUT;
         end
         ST_OUT: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `SFM_ASSERT_NOW(a_load_out_free, clock, reset, cmd.load_out, stat.out_free)
   `SFM_ASSERT_NEXT(a_div_to_blend, clock, reset, cmd.div_step && stat.div_last, state_ff == ST_BMUL)
   `SFM_ASSERT_NEXT(a_open_window, clock, reset, (state_ff == ST_CHK) && !stat.win_closed, state_ff == ST_OUT)

endmodule

// ===== hw/rtl/sfm_dp.sv =====
// Datapath: accumulators, rate multiplier, shift-subtract divider, blend and result register.
`include "smoothed_frequency_meter_defines.svh"

module sfm_dp #(
   parameter int FREQ_FRAC_BITS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  sfm_pkg::sfm_cmd_type         cmd,
   output sfm_pkg::sfm_stat_type        stat,
   input  logic                         item_action,
   input  logic [sfm_pkg::STAMP_W-1:0]  item_stamp,
   input  logic [sfm_pkg::COUNT_W-1:0]  item_count,
   input  logic [sfm_pkg::MOM_W-1:0]    momentum,
   input  logic [sfm_pkg::WIN_W-1:0]    window,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [sfm_pkg::FREQ_W-1:0]   rsp_freq,
   output logic                         rsp_updated
);
   import sfm_pkg::*;

   localparam int NUM_W = PROD_W + FREQ_FRAC_BITS;
   localparam int TOP_W = NUM_W - FREQ_W;
   localparam int MIX_W = FREQ_W + MOM_W + 1;

   // Item registers.
   logic               action_ff, action_in;
   logic [STAMP_W-1:0] stamp_ff, stamp_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   // Kept state.
   logic [STAMP_W-1:0] last_stamp_ff, last_stamp_in;
   logic [SUM_W-1:0]   count_sum_ff, count_sum_in;
   logic [SUM_W-1:0]   time_sum_ff, time_sum_in;
   logic [FREQ_W-1:0]  smoothed_ff, smoothed_in;
   logic               upd_ff, upd_in;

   // Rate computation.
   logic [PROD_W-1:0]    num_ff, num_in;
   logic [SUM_W-1:0]     rem_ff, rem_in;
   logic [FREQ_W-1:0]    quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] step_ff, step_in;
   logic [MIX_W-2:0]     p_old_ff, p_old_in;
   logic [MIX_W-1:0]     p_new_ff, p_new_in;

   // Result register.
   logic              out_valid_ff, out_valid_in;
   logic [FREQ_W-1:0] out_freq_ff, out_freq_in;
   logic              out_upd_ff, out_upd_in;

   logic [SUM_W-1:0]  elapsed;
   logic [SUM_W:0]    tsum_wide;
   logic [SUM_W:0]    csum_wide;
   logic [NUM_W-1:0]  num_sh;
   logic [TOP_W-1:0]  num_top;
   logic              top_ge;
   logic [SUM_W:0]    rem_sh;
   logic              rem_ge;
   logic [SUM_W:0]    rem_diff;
   logic [MIX_W-1:0]  mix_sum;

   assign elapsed   = stamp_ff - last_stamp_ff;
   assign tsum_wide = {1'b0, time_sum_ff} + {1'b0, elapsed};
   assign csum_wide = {1'b0, count_sum_ff} + (SUM_W + 1)'(count_ff);

   // The scaled numerator; its bits above the quotient width form the first
   // partial remainder, and a quotient bit there means saturation.
   assign num_sh  = NUM_W'(num_ff) << FREQ_FRAC_BITS;
   assign num_top = num_sh[NUM_W-1:FREQ_W];
   assign top_ge  = SUM_W'(num_top) >= time_sum_ff;

   // The numerator's low bits travel through quo_ff and are replaced by
   // quotient bits, one per step.
   assign rem_sh   = {rem_ff, quo_ff[FREQ_W-1]};
   assign rem_ge   = rem_sh >= {1'b0, time_sum_ff};
   assign rem_diff = rem_sh - {1'b0, time_sum_ff};

   assign mix_sum = {1'b0, p_old_ff} + p_new_ff;

   assign stat.win_closed = time_sum_ff > SUM_W'(window);
   assign stat.rate_sat   = top_ge;
   assign stat.div_last   = (step_ff == DIV_CNT_W'(FREQ_W - 1));
   assign stat.out_free   = !out_valid_ff || rsp_ready;

   assign rsp_valid   = out_valid_ff;
   assign rsp_freq    = out_freq_ff;
   assign rsp_updated = out_upd_ff;

   always_comb begin
      action_in     = action_ff;
      stamp_in      = stamp_ff;
      count_in      = count_ff;
      last_stamp_in = last_stamp_ff;
      count_sum_in  = count_sum_ff;
      time_sum_in   = time_sum_ff;
      smoothed_in   = smoothed_ff;
      upd_in        = upd_ff;
      num_in        = num_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      step_in       = step_ff;
      p_old_in      = p_old_ff;
      p_new_in      = p_new_ff;
      out_valid_in  = out_valid_ff;
      out_freq_in   = out_freq_ff;
      out_upd_in    = out_upd_ff;

      if (cmd.load_item) begin
         action_in = item_action;
         stamp_in  = item_stamp;
         count_in  = item_count;
      end

      if (cmd.accumulate) begin
         upd_in        = 1'b0;
         last_stamp_in = stamp_ff;
         if (action_ff == ACTION_RESTART) begin
            count_sum_in = '0;
            time_sum_in  = '0;
         end else begin
            time_sum_in  = tsum_wide[SUM_W] ? '1 : tsum_wide[SUM_W-1:0];
            count_sum_in = csum_wide[SUM_W] ? '1 : csum_wide[SUM_W-1:0];
         end
      end

      if (cmd.mul) begin
         num_in = PROD_W'(count_sum_ff) * PROD_W'(US_PER_SEC);
      end

      if (cmd.div_init) begin
         step_in = '0;
         if (top_ge) begin
            rem_in = '0;
            quo_in = '1;
         end else begin
            rem_in = SUM_W'(num_top);
            quo_in = num_sh[FREQ_W-1:0];
         end
      end

      if (cmd.div_step) begin
         rem_in  = rem_ge ? rem_diff[SUM_W-1:0] : rem_sh[SUM_W-1:0];
         quo_in  = {quo_ff[FREQ_W-2:0], rem_ge};
         step_in = step_ff + DIV_CNT_W'(1);
      end

      if (cmd.blend_mul) begin
         p_old_in = (MIX_W - 1)'(smoothed_ff) * (MIX_W - 1)'(momentum);
         p_new_in = MIX_W'(quo_ff) * MIX_W'(ONE_Q16 - {1'b0, momentum});
      end

      if (cmd.blend_sum) begin
         smoothed_in  = mix_sum[MOM_W +: FREQ_W];
         count_sum_in = '0;
         time_sum_in  = '0;
         upd_in       = 1'b1;
      end

      if (cmd.load_out) begin
         out_valid_in = 1'b1;
         out_freq_in  = smoothed_ff;
         out_upd_in   = upd_ff;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_stamp_ff <= '0;
         count_sum_ff  <= '0;
         time_sum_ff   <= '0;
         smoothed_ff   <= '0;
         upd_ff        <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         last_stamp_ff <= last_stamp_in;
         count_sum_ff  <= count_sum_in;
         time_sum_ff   <= time_sum_in;
         smoothed_ff   <= smoothed_in;
         upd_ff        <= upd_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff   <= action_in;
      stamp_ff    <= stamp_in;
      count_ff    <= count_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      step_ff     <= step_in;
      p_old_ff    <= p_old_in;
      p_new_ff    <= p_new_in;
      out_freq_ff <= out_freq_in;
      out_upd_ff  <= out_upd_in;
   end

   `SFM_ASSERT_NOW(a_rem_below_divisor, clock, reset, cmd.div_step, rem_ff < time_sum_ff)
   `SFM_ASSERT_NEXT(a_sums_cleared, clock, reset, cmd.blend_sum, (count_sum_ff == '0) && (time_sum_ff == '0))

endmodule

// ===== hw/rtl/smoothed_frequency_meter.sv =====
// Top level of the smoothed frequency meter: register file, controller and datapath.
//
//   channel   direction  handshake      payload
//   req_bus   in         valid / ready  action, timestamp_us, event_count
//   rsp_bus   out        valid / ready  frequency_q8, updated
//   csr_bus   in         valid / ready  index, wdata (always ready)
//
// An item that leaves the window open, or a restart item, passes from acceptance
// through the accumulate, check and output states; one that closes the window also
// passes the multiply, shift-subtract divider and blend states; the divider is skipped on saturation.
// Reset clears the accumulators, the last stamp, the frequency and the result
// valid flag, and loads the register defaults; the block is ready at once.
// A waiting result does not stop the next item being accepted; only the
// hand-over of that next result waits for the result register to free up.
module smoothed_frequency_meter #(
   parameter int FREQ_FRAC_BITS = 8
) (
   input logic         clock,
   input logic         reset,
   sfm_req_if.sink     req_bus,
   sfm_rsp_if.source   rsp_bus,
   sfm_csr_if.sink     csr_bus
);
   import sfm_pkg::*;

   logic [MOM_W-1:0] momentum_ff, momentum_in;
   logic [WIN_W-1:0] window_ff, window_in;

   sfm_cmd_type  cmd;
   sfm_stat_type stat;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      momentum_in = momentum_ff;
      window_in   = window_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_MOMENTUM: momentum_in = csr_bus.wdata[MOM_W-1:0];
            CSR_WINDOW:   window_in   = csr_bus.wdata[WIN_W-1:0];
            default: begin
               momentum_in = momentum_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         momentum_ff <= MOMENTUM_RESET;
         window_ff   <= WINDOW_RESET;
      end else begin
         momentum_ff <= momentum_in;
         window_ff   <= window_in;
      end
   end

   sfm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   sfm_dp #(
      .FREQ_FRAC_BITS (FREQ_FRAC_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .item_action (req_bus.action),
      .item_stamp  (req_bus.timestamp_us),
      .item_count  (req_bus.event_count),
      .momentum    (momentum_ff),
      .window      (window_ff),
      .rsp_valid   (rsp_bus.valid),
      .rsp_ready   (rsp_bus.ready),
      .rsp_freq    (rsp_bus.frequency_q8),
      .rsp_updated (rsp_bus.updated)
   );

endmodule
